/* design/mbe_pkg.sv */
// Mandelbrot escape-time package: sequencer states, register indexes and
// channel payload types. No dependencies.
`default_nettype none

package mbe_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int OUT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 2'd1;

    localparam logic [CFG_DAT_W-1:0] MAX_ITER_RST = 9'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XY,
        ST_UPD,
        ST_XX,
        ST_YY,
        ST_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
    } point_t;

    typedef struct packed {
        logic [OUT_W-1:0] iteration_count;
        logic             escaped;
        logic [OUT_W-1:0] color_index;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

/* design/mbe_chan_if.sv */
// Valid/ready channel carrying one payload per transaction.
// Payload type is supplied by the instantiating level (types from mbe_pkg).
`default_nettype none

interface mbe_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/mbe_mul.sv */
// Shared signed 32x32 multiplier with registered 64-bit product.
// Depends on mbe_pkg.
`default_nettype none

module mbe_mul
    import mbe_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [DATA_W-1:0]   a,
    input  wire logic signed [DATA_W-1:0]   b,
    output logic signed [2*DATA_W-1:0]      prod
);

    logic signed [2*DATA_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time.sv */
// Mandelbrot escape-time top level: sequencer, state registers, output stage.
// Depends on mbe_pkg, mbe_chan_if and mbe_mul.
//
// One point is taken at a time. Each iteration of z = z*z + c runs through
// the single shared multiplier three times (x*y, x*x, y*y) and steps through
// the states ST_XY, ST_UPD, ST_XX, ST_YY and ST_CHK; a point runs at most
// max_iterations - 1 steps, fewer when the point escapes.
// The point port is ready only while the sequencer is idle; a finished
// result sits in an output register, so a new point can be taken while the
// previous result waits. Configuration writes are always accepted and
// should only be issued while no point is in flight.
`default_nettype none

module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int ITER_LIMIT = 256
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mbe_chan_if.sink   cfg,
    mbe_chan_if.sink   point,
    mbe_chan_if.source result
);

    localparam int SQ_W   = 2*DATA_W - FRAC_BITS;
    localparam int SXY_W  = SQ_W + 1;
    localparam int SUM_W  = ((SXY_W > DATA_W) ? SXY_W : DATA_W) + 1;
    localparam int CHK_W  = ((SXY_W > FRAC_BITS + 4) ? SXY_W : FRAC_BITS + 4);
    localparam int CNT_W  = $clog2(ITER_LIMIT);
    localparam int LIMB_W = $clog2(ITER_LIMIT + 1);
    localparam int LIM_W  = (LIMB_W > CFG_DAT_W) ? LIMB_W : CFG_DAT_W;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fffffff);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh80000000);
    localparam logic signed [CHK_W-1:0] BOUND  =
        {{(CHK_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);

    state_t                     state_reg, state_next;
    logic [CFG_DAT_W-1:0]       max_iter_reg;
    logic [2:0]                 shift_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       esc_reg, esc_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg, out_next;

    logic signed [DATA_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [DATA_W-1:0]   cr_reg, cr_next, ci_reg, ci_next;
    logic signed [SQ_W-1:0]     sx_reg, sx_next, sy_reg, sy_next;

    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [2*DATA_W-1:0] prod;

    logic signed [SQ_W-1:0]     sq_cur;
    logic signed [SXY_W-1:0]    xy_sh;
    logic signed [SUM_W-1:0]    ny_sum, nx_sum;
    logic signed [DATA_W-1:0]   ny_sat, nx_sat;
    logic signed [CHK_W-1:0]    mag;
    logic                       escape_hit;

    logic [LIM_W-1:0]           mi_ext, lim_eff, lim_m1, cnt_inc;

    mbe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Step limit: zero acts as one, anything above ITER_LIMIT is clamped
    assign mi_ext  = LIM_W'(max_iter_reg);
    assign lim_eff = (mi_ext == '0) ? LIM_W'(1) :
                     ((mi_ext > LIM_W'(ITER_LIMIT)) ? LIM_W'(ITER_LIMIT) : mi_ext);
    assign lim_m1  = lim_eff - LIM_W'(1);
    assign cnt_inc = LIM_W'(count_reg) + LIM_W'(1);

    // Floor shifts of the registered product
    assign sq_cur = SQ_W'(prod >>> FRAC_BITS);
    assign xy_sh  = SXY_W'(prod >>> (FRAC_BITS - 1));

    assign ny_sum = SUM_W'(xy_sh) + SUM_W'(ci_reg);
    assign nx_sum = SUM_W'(sx_reg) - SUM_W'(sy_reg) + SUM_W'(cr_reg);
    assign ny_sat = (ny_sum > SAT_HI) ? 32'sh7fffffff :
                    ((ny_sum < SAT_LO) ? 32'sh80000000 : DATA_W'(ny_sum));
    assign nx_sat = (nx_sum > SAT_HI) ? 32'sh7fffffff :
                    ((nx_sum < SAT_LO) ? 32'sh80000000 : DATA_W'(nx_sum));

    assign mag        = CHK_W'(sx_reg) + CHK_W'(sq_cur);
    assign escape_hit = (mag >= BOUND);

    assign cfg.ready     = 1'b1;
    assign point.ready   = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        esc_next       = esc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        mul_a          = x_reg;
        mul_b          = y_reg;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (point.valid)
                begin
                    cr_next    = point.payload.c_real;
                    ci_next    = point.payload.c_imag;
                    x_next     = '0;
                    y_next     = '0;
                    sx_next    = '0;
                    sy_next    = '0;
                    count_next = '0;
                    esc_next   = 1'b0;
                    state_next = (lim_m1 == '0) ? ST_DONE : ST_XY;
                end
            end
            ST_XY:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                x_next     = nx_sat;
                y_next     = ny_sat;
                state_next = ST_XX;
            end
            ST_XX:
            begin
                mul_b      = x_reg;
                state_next = ST_YY;
            end
            ST_YY:
            begin
                mul_a      = y_reg;
                sx_next    = sq_cur;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                sy_next = sq_cur;
                if (escape_hit)
                begin
                    esc_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = (cnt_inc < lim_m1) ? ST_XY : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next.iteration_count = OUT_W'(count_reg);
                    out_next.escaped         = esc_reg;
                    out_next.color_index     = OUT_W'(count_reg >> shift_reg);
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= MAX_ITER_RST;
            shift_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.payload.index)
                    REG_MAX_ITER: max_iter_reg <= cfg.payload.data;
                    REG_SHIFT:    shift_reg    <= cfg.payload.data[2:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
    end

endmodule

`default_nettype wire
